>>> hw/rtl/serial_radio_link_model_core_assert.svh
// Assertion macros for the serial radio link model core checker.
// No dependencies; included by the checker file.
`ifndef SERIAL_RADIO_LINK_MODEL_CORE_ASSERT_SVH
`define SERIAL_RADIO_LINK_MODEL_CORE_ASSERT_SVH

// clocked check, off while reset is high
`define SRLM_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("srlm check failed");

// clocked check that also holds through reset
`define SRLM_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("srlm reset check failed");

`endif

>>> hw/rtl/srlm_pkg.sv
// Shared constants for the serial radio link model core and its checker.
// No dependencies.
package srlm_pkg;

  // input kinds (tuser)
  localparam logic [1:0] KIND_CS_RELEASE = 2'd0;
  localparam logic [1:0] KIND_SCLK_RISE  = 2'd1;
  localparam logic [1:0] KIND_TICK       = 2'd2;

  // commands
  localparam logic [7:0] CMD_TX_START   = 8'hd0;
  localparam logic [7:0] CMD_WAIT_RESET = 8'hc0;
  localparam logic [7:0] CMD_LATCH_RX   = 8'h45;
  localparam logic [1:0] CMD_CLASS_READ = 2'b01;   // cmd[7:6] of read-class commands

  localparam logic [7:0] PKT_HEADER   = 8'h56;
  localparam int         PACKET_BYTES = 24;

  // config register indexes
  localparam logic [1:0] REG_TX_DONE_DELAY = 2'd0;
  localparam logic [1:0] REG_REPLY_DELAY   = 2'd1;
  localparam logic [1:0] REG_ACCEL_STEP    = 2'd2;
  localparam logic [1:0] REG_ACCEL_LIMIT   = 2'd3;

  localparam logic [7:0]  RST_TX_DONE_DELAY = 8'd5;
  localparam logic [7:0]  RST_REPLY_DELAY   = 8'd30;
  localparam logic [15:0] RST_ACCEL_STEP    = 16'd1000;
  localparam logic [15:0] RST_ACCEL_LIMIT   = 16'd40000;

  // stream widths and output field positions
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 8;
  localparam int OUT_DRIVE_VALID = 0;
  localparam int OUT_DRIVE_BIT   = 1;
  localparam int OUT_STATUS      = 2;
  localparam int OUT_IRQ_LO      = 3;
  localparam int OUT_IRQ_HI      = 4;

endpackage

>>> hw/rtl/serial_radio_link_model_core.sv
// Serial radio link slave model core: command decode, delay timers, motion ramp.
// Depends on srlm_pkg.
//
// Usage:
//   Input stream s_*: one event per transfer. s_tuser = kind (0 chip-select
//   release, 1 serial clock rising edge, 2 time tick). s_tdata carries the
//   sampled data bit, the motion flag and the button mask.
//   Output stream m_*: exactly one result per input event, in order: drive
//   valid, driven bit, status level after the event, falling interrupts fired.
//   APB port: four config registers at byte addresses 0, 4, 8, 12; write them
//   only while the block is idle.
// Each result is registered into the output register, or into the skid entry while m_* stalls.
// Throughput: one event per cycle while s_tready is high; every event is handled by
//   combinational logic between the state registers and the output register.
// Stall: an output register plus one skid entry; s_tready drops only when
//   both hold results, so one more event is taken after m_tready goes low.
// Reset: link state clears (snapshot words excepted), status level goes high,
//   config returns to its defaults, and both output entries empty.
module serial_radio_link_model_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [0] data_bit, [1] motion, [17:2] button_mask, rest 0
  input  logic [1:0]  s_tuser,   // [1:0] kind
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] drive_valid, [1] drive_bit, [2] status, [4:3] irq_count
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TX,
    PH_WAIT,
    PH_DONE
  } phase_t;

  // config
  logic [7:0]  tx_done_delay;
  logic [7:0]  reply_delay;
  logic [15:0] accel_step;
  logic [15:0] accel_limit;

  // link state
  logic [7:0]  shift_reg, shift_reg_next;
  logic [2:0]  bit_count, bit_count_next;
  logic [4:0]  byte_count, byte_count_next;
  logic [7:0]  current_command, current_command_next;
  logic        read_buffer_loaded, read_buffer_loaded_next;
  logic        packet_present, packet_present_next;
  phase_t      link_phase, link_phase_next;
  logic [7:0]  elapsed_ticks, elapsed_ticks_next;
  logic        timer_armed, timer_armed_next;
  logic        any_tick_seen, any_tick_seen_next;
  logic        status_level, status_level_next;
  // all three axes ramp together, so one value stands for x, y and z
  logic [15:0] motion_value, motion_value_next;
  logic [15:0] snap_motion, snap_motion_next;
  logic [15:0] snap_buttons, snap_buttons_next;
  logic [15:0] read_motion, read_motion_next;
  logic [15:0] read_buttons, read_buttons_next;

  // output register and skid entry
  logic        out_valid, skid_valid;
  logic [7:0]  out_data, skid_data;

  logic        in_xfer;
  logic [1:0]  kind;
  logic        data_bit, motion;
  logic [15:0] button_mask;
  logic        cmd_fire;
  logic [7:0]  cmd_byte;
  logic [7:0]  shifted_in;
  logic [16:0] ramp_sum;
  logic [4:0]  pkt_idx;
  logic [7:0]  pkt_byte;
  logic        drive_valid, drive_bit;
  logic [1:0]  irq_count;
  logic [7:0]  result;
  logic        cfg_write;

  assign kind        = s_tuser;
  assign data_bit    = s_tdata[0];
  assign motion      = s_tdata[1];
  assign button_mask = s_tdata[17:2];

  assign s_tready = !skid_valid;
  assign in_xfer  = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // reply packet byte as seen by reads
  function automatic logic [7:0] packet_byte(input logic [4:0] idx, input logic loaded,
                                             input logic [15:0] mot, input logic [15:0] btn);
    logic [15:0] w;
    w = (idx < 5'd12) ? mot : btn;
    if (!loaded || idx >= 5'(srlm_pkg::PACKET_BYTES))
      return 8'd0;
    else if (idx == 5'd0)
      return srlm_pkg::PKT_HEADER;
    else if (idx >= 5'd6 && idx <= 5'd13)
      return idx[0] ? w[15:8] : w[7:0];
    else
      return 8'd0;
  endfunction

  always_comb begin
    shift_reg_next          = shift_reg;
    bit_count_next          = bit_count;
    byte_count_next         = byte_count;
    current_command_next    = current_command;
    read_buffer_loaded_next = read_buffer_loaded;
    packet_present_next     = packet_present;
    link_phase_next         = link_phase;
    elapsed_ticks_next      = elapsed_ticks;
    timer_armed_next        = timer_armed;
    any_tick_seen_next      = any_tick_seen;
    status_level_next       = status_level;
    motion_value_next       = motion_value;
    snap_motion_next        = snap_motion;
    snap_buttons_next       = snap_buttons;
    read_motion_next        = read_motion;
    read_buttons_next       = read_buttons;
    cmd_fire    = 1'b0;
    cmd_byte    = shift_reg;
    shifted_in  = shift_reg;
    ramp_sum    = 17'd0;
    pkt_idx     = 5'd0;
    pkt_byte    = 8'd0;
    drive_valid = 1'b0;
    drive_bit   = 1'b0;
    irq_count   = 2'd0;

    // counters and the byte that may complete a command
    case (kind)
      srlm_pkg::KIND_CS_RELEASE: begin
        // partial byte is left-aligned before decode
        cmd_fire = (bit_count != 3'd0);
        cmd_byte = shift_reg << (3'd0 - bit_count);
      end
      srlm_pkg::KIND_SCLK_RISE: begin
        if (current_command[7:6] != srlm_pkg::CMD_CLASS_READ)
          shifted_in = {shift_reg[6:0], data_bit};
        cmd_byte = shifted_in;
        if (bit_count == 3'd7) begin
          cmd_fire       = (byte_count == 5'd0);
          shift_reg_next = 8'd0;
          bit_count_next = 3'd0;
          if (byte_count != 5'd31)
            byte_count_next = byte_count + 5'd1;
        end else begin
          shift_reg_next = shifted_in;
          bit_count_next = bit_count + 3'd1;
        end
      end
      default: ;
    endcase

    if (cmd_fire) begin
      current_command_next    = cmd_byte;
      read_buffer_loaded_next = 1'b0;
      if (cmd_byte == srlm_pkg::CMD_TX_START || cmd_byte == srlm_pkg::CMD_WAIT_RESET) begin
        timer_armed_next   = any_tick_seen;
        elapsed_ticks_next = 8'd0;
        if (cmd_byte == srlm_pkg::CMD_TX_START)
          link_phase_next = PH_TX;
        else if (link_phase == PH_WAIT)
          status_level_next = 1'b1;
      end else if (cmd_byte == srlm_pkg::CMD_LATCH_RX) begin
        read_buffer_loaded_next = packet_present;
        read_motion_next        = snap_motion;
        read_buttons_next       = snap_buttons;
        status_level_next       = 1'b1;
      end
    end

    case (kind)
      srlm_pkg::KIND_CS_RELEASE: begin
        current_command_next = 8'd0;
        bit_count_next       = 3'd0;
        byte_count_next      = 5'd0;
        shift_reg_next       = 8'd0;
      end
      srlm_pkg::KIND_SCLK_RISE: begin
        if (byte_count_next != 5'd0 &&
            current_command_next[7:6] == srlm_pkg::CMD_CLASS_READ) begin
          pkt_idx     = byte_count_next - 5'd1;
          pkt_byte    = packet_byte(pkt_idx, read_buffer_loaded_next,
                                    read_motion_next, read_buttons_next);
          drive_valid = 1'b1;
          drive_bit   = pkt_byte[~bit_count_next];
        end
      end
      srlm_pkg::KIND_TICK: begin
        any_tick_seen_next = 1'b1;
        if (elapsed_ticks != 8'hff)
          elapsed_ticks_next = elapsed_ticks + 8'd1;
        // both events may fire on the same tick
        if (timer_armed && link_phase == PH_TX && elapsed_ticks_next >= tx_done_delay) begin
          status_level_next = 1'b0;
          irq_count         = 2'd1;
          link_phase_next   = PH_WAIT;
        end
        if (timer_armed && link_phase_next == PH_WAIT &&
            elapsed_ticks_next >= reply_delay) begin
          snap_motion_next    = motion_value;
          snap_buttons_next   = button_mask;
          packet_present_next = 1'b1;
          status_level_next   = 1'b0;
          irq_count           = irq_count + 2'd1;
          link_phase_next     = PH_DONE;
        end
        ramp_sum = {1'b0, motion_value} + {1'b0, accel_step};
        if (motion)
          motion_value_next = (ramp_sum > {1'b0, accel_limit}) ? accel_limit : ramp_sum[15:0];
        else
          motion_value_next = (motion_value > accel_step) ? motion_value - accel_step : 16'd0;
      end
      default: ;
    endcase
  end

  always_comb begin
    result = 8'd0;
    result[srlm_pkg::OUT_DRIVE_VALID]                    = drive_valid;
    result[srlm_pkg::OUT_DRIVE_BIT]                      = drive_bit;
    result[srlm_pkg::OUT_STATUS]                         = status_level_next;
    result[srlm_pkg::OUT_IRQ_HI:srlm_pkg::OUT_IRQ_LO]    = irq_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_reg          <= 8'd0;
      bit_count          <= 3'd0;
      byte_count         <= 5'd0;
      current_command    <= 8'd0;
      read_buffer_loaded <= 1'b0;
      packet_present     <= 1'b0;
      link_phase         <= PH_IDLE;
      elapsed_ticks      <= 8'd0;
      timer_armed        <= 1'b0;
      any_tick_seen      <= 1'b0;
      status_level       <= 1'b1;
      motion_value       <= 16'd0;
    end else if (in_xfer) begin
      shift_reg          <= shift_reg_next;
      bit_count          <= bit_count_next;
      byte_count         <= byte_count_next;
      current_command    <= current_command_next;
      read_buffer_loaded <= read_buffer_loaded_next;
      packet_present     <= packet_present_next;
      link_phase         <= link_phase_next;
      elapsed_ticks      <= elapsed_ticks_next;
      timer_armed        <= timer_armed_next;
      any_tick_seen      <= any_tick_seen_next;
      status_level       <= status_level_next;
      motion_value       <= motion_value_next;
    end
  end

  // snapshot words are only read after a packet has been latched
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      snap_motion  <= snap_motion_next;
      snap_buttons <= snap_buttons_next;
      read_motion  <= read_motion_next;
      read_buttons <= read_buttons_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_xfer;
        out_data  <= result;
      end
    end else if (in_xfer) begin
      skid_valid <= 1'b1;
      skid_data  <= result;
    end
  end

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_done_delay <= srlm_pkg::RST_TX_DONE_DELAY;
      reply_delay   <= srlm_pkg::RST_REPLY_DELAY;
      accel_step    <= srlm_pkg::RST_ACCEL_STEP;
      accel_limit   <= srlm_pkg::RST_ACCEL_LIMIT;
    end else if (cfg_write) begin
      case (paddr[3:2])
        srlm_pkg::REG_TX_DONE_DELAY: tx_done_delay <= pwdata[7:0];
        srlm_pkg::REG_REPLY_DELAY:   reply_delay   <= pwdata[7:0];
        srlm_pkg::REG_ACCEL_STEP:    accel_step    <= pwdata[15:0];
        srlm_pkg::REG_ACCEL_LIMIT:   accel_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      srlm_pkg::REG_TX_DONE_DELAY: prdata = {24'd0, tx_done_delay};
      srlm_pkg::REG_REPLY_DELAY:   prdata = {24'd0, reply_delay};
      srlm_pkg::REG_ACCEL_STEP:    prdata = {16'd0, accel_step};
      srlm_pkg::REG_ACCEL_LIMIT:   prdata = {16'd0, accel_limit};
      default:                     prdata = 32'd0;
    endcase
  end

endmodule

>>> hw/rtl/srlm_checker.sv
// Port-level checker for serial_radio_link_model_core, bound to the top level.
// Depends on srlm_pkg and serial_radio_link_model_core_assert.svh.
`include "serial_radio_link_model_core_assert.svh"

module srlm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [srlm_pkg::M_TDATA_W-1:0] m_tdata
);

  // at most two interrupts fire on one tick
  `SRLM_ASSERT_CLK(a_irq_le_two, m_tvalid |-> m_tdata[srlm_pkg::OUT_IRQ_HI:srlm_pkg::OUT_IRQ_LO] != 2'b11)

  // driven bit reads zero unless the line is driven
  `SRLM_ASSERT_CLK(a_drive_bit_quiet, m_tvalid && !m_tdata[srlm_pkg::OUT_DRIVE_VALID] |-> !m_tdata[srlm_pkg::OUT_DRIVE_BIT])

  // input side only backs up once the output entry is full
  `SRLM_ASSERT_CLK(a_stall_needs_output, !s_tready |-> m_tvalid)

  // a stalled result holds
  `SRLM_ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // coming out of reset both output entries are empty
  `SRLM_ASSERT_ALWAYS(a_reset_empty, $fell(rst) |-> !m_tvalid && s_tready)

endmodule

bind serial_radio_link_model_core srlm_checker u_srlm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> dv/testbench.sv
// Self-checking bench for serial_radio_link_model_core: directed table then random traffic.
// Carries its own model of the link; depends on srlm_pkg and the core RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam logic [1:0] KIND_UNUSED = 2'd3;   // ignored by the core
  localparam logic [7:0] CMD_DATA_DROP = 8'h05;
  localparam logic [7:0] CMD_READ_BASE = 8'h40;
  localparam int QUIET_LIMIT = 5000;

  typedef enum logic [1:0] {PH_IDLE, PH_TX, PH_WAIT, PH_DONE} link_phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        dbit;
    logic        mot;
    logic [15:0] buttons;
  } link_event_t;

  typedef struct packed {
    logic       drv_valid;
    logic       drv_bit;
    logic       status;
    logic [1:0] irqs;
  } link_result_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        dbit;
    logic        mot;
    logic [15:0] buttons;
    logic        typed;
    logic        drv_valid;
    logic        drv_bit;
    logic        status;
    logic [1:0]  irqs;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // [0] data_bit, [1] motion, [17:2] button_mask, rest 0
  logic [1:0]  s_tuser = '0;   // [1:0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [0] drive_valid, [1] drive_bit, [2] status, [4:3] irq_count
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  serial_radio_link_model_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- link model
  logic [7:0]  cfg_tx_delay, cfg_reply_delay;
  logic [15:0] cfg_step, cfg_limit;

  logic [7:0]  sh_byte, cmd_now;
  int unsigned bit_idx, byte_idx, ticks_since;
  bit          rd_loaded, pkt_ready, armed, ticked;
  logic [15:0] snap [4];
  logic [15:0] rd_copy [4];
  int unsigned axis [3];
  link_phase_t phase;
  logic        status_q;

  function automatic void link_reset();
    cfg_tx_delay = srlm_pkg::RST_TX_DONE_DELAY;
    cfg_reply_delay = srlm_pkg::RST_REPLY_DELAY;
    cfg_step = srlm_pkg::RST_ACCEL_STEP;
    cfg_limit = srlm_pkg::RST_ACCEL_LIMIT;
    sh_byte = '0;
    cmd_now = '0;
    bit_idx = 0;
    byte_idx = 0;
    ticks_since = 0;
    rd_loaded = 0;
    pkt_ready = 0;
    armed = 0;
    ticked = 0;
    snap = '{default: '0};
    rd_copy = '{default: '0};
    axis = '{default: 0};
    phase = PH_IDLE;
    status_q = 1'b1;
  endfunction

  function automatic logic [7:0] reply_byte(input int unsigned idx);
    logic [15:0] w;
    if (idx >= srlm_pkg::PACKET_BYTES || !rd_loaded) return 8'h00;
    if (idx == 0) return srlm_pkg::PKT_HEADER;
    if (idx >= 6 && idx <= 13) begin
      w = rd_copy[(idx - 6) >> 1];
      return idx[0] ? w[15:8] : w[7:0];
    end
    return 8'h00;
  endfunction

  function automatic void take_command();
    cmd_now = sh_byte;
    rd_loaded = 0;
    if (cmd_now == srlm_pkg::CMD_TX_START || cmd_now == srlm_pkg::CMD_WAIT_RESET) begin
      armed = ticked;
      ticks_since = 0;
      if (cmd_now == srlm_pkg::CMD_TX_START) phase = PH_TX;
      else if (phase == PH_WAIT) status_q = 1'b1;
    end else if (cmd_now == srlm_pkg::CMD_LATCH_RX) begin
      rd_loaded = pkt_ready;
      rd_copy = snap;
      status_q = 1'b1;
    end
  endfunction

  function automatic link_result_t link_event(input link_event_t ev);
    link_result_t r;
    logic [7:0] b;
    int unsigned v;
    int i;
    r = '0;
    case (ev.kind)
      srlm_pkg::KIND_CS_RELEASE: begin
        // a partial byte is left-aligned and taken as a command
        if (bit_idx > 0) begin
          sh_byte = sh_byte << (8 - bit_idx);
          take_command();
        end
        cmd_now = '0;
        bit_idx = 0;
        byte_idx = 0;
        sh_byte = '0;
      end
      srlm_pkg::KIND_SCLK_RISE: begin
        if (cmd_now[7:6] != srlm_pkg::CMD_CLASS_READ) sh_byte = {sh_byte[6:0], ev.dbit};
        bit_idx++;
        if (bit_idx >= 8) begin
          if (byte_idx == 0) take_command();
          sh_byte = '0;
          bit_idx = 0;
          if (byte_idx < 31) byte_idx++;
        end
        if (byte_idx > 0 && cmd_now[7:6] == srlm_pkg::CMD_CLASS_READ) begin
          b = reply_byte(byte_idx - 1);
          r.drv_valid = 1'b1;
          r.drv_bit = b[(7 - bit_idx) & 7];
        end
      end
      srlm_pkg::KIND_TICK: begin
        ticked = 1;
        if (ticks_since < 255) ticks_since++;
        if (armed && phase == PH_TX && ticks_since >= cfg_tx_delay) begin
          status_q = 1'b0;
          r.irqs++;
          phase = PH_WAIT;
        end
        if (armed && phase == PH_WAIT && ticks_since >= cfg_reply_delay) begin
          for (i = 0; i < 3; i++) snap[i] = axis[i][15:0];
          snap[3] = ev.buttons;
          pkt_ready = 1;
          status_q = 1'b0;
          r.irqs++;
          phase = PH_DONE;
        end
        for (i = 0; i < 3; i++) begin
          v = axis[i];
          if (ev.mot) begin
            v = v + cfg_step;
            if (v > cfg_limit) v = cfg_limit;
          end else begin
            v = (v > cfg_step) ? v - cfg_step : 0;
          end
          axis[i] = v & 16'hffff;
        end
      end
      default: ;
    endcase
    r.status = status_q;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  link_result_t pending_results [$];
  int errors = 0;

  always @(posedge clk) begin
    link_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: m_tdata=%h", m_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[srlm_pkg::OUT_DRIVE_VALID] !== want.drv_valid) begin
          $error("drive_valid: expected %0d, got %0d", want.drv_valid,
                 m_tdata[srlm_pkg::OUT_DRIVE_VALID]);
          errors++;
        end
        if (m_tdata[srlm_pkg::OUT_DRIVE_BIT] !== want.drv_bit) begin
          $error("drive_bit: expected %0d, got %0d", want.drv_bit,
                 m_tdata[srlm_pkg::OUT_DRIVE_BIT]);
          errors++;
        end
        if (m_tdata[srlm_pkg::OUT_STATUS] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[srlm_pkg::OUT_STATUS]);
          errors++;
        end
        if (m_tdata[srlm_pkg::OUT_IRQ_HI:srlm_pkg::OUT_IRQ_LO] !== want.irqs) begin
          $error("irq_count: expected %0d, got %0d", want.irqs,
                 m_tdata[srlm_pkg::OUT_IRQ_HI:srlm_pkg::OUT_IRQ_LO]);
          errors++;
        end
      end
    end
  end

  // receiver backpressure: modes of random length, one of them never stalls
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 128);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ~m_tready;
    endcase
  end

  int unsigned quiet = 0;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet <= 0;
    else quiet <= quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("** serial_radio_link_model_core: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;
  bit mot_up = 1'b1;

  task automatic push_event(input link_event_t ev, input bit typed = 1'b0,
                            input link_result_t want = '0);
    int unsigned gap;
    link_result_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {6'b0, ev.buttons, ev.mot, ev.dbit};
    s_tuser <= ev.kind;
    do @(posedge clk); while (!s_tready);
    got = link_event(ev);
    pending_results.insert(pending_results.size(), typed ? want : got);
    if (ev.kind != KIND_UNUSED) items_sent++;
  endtask

  function automatic logic [15:0] rand_buttons();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic link_event_t rand_event(input logic [1:0] kind, input logic dbit);
    link_event_t ev;
    ev.kind = kind;
    ev.dbit = dbit;
    ev.mot = 1'($urandom_range(0, 1));
    ev.buttons = rand_buttons();
    return ev;
  endfunction

  task automatic send_bits(input logic [7:0] val, input int n);
    int i;
    for (i = 0; i < n; i++)
      push_event(rand_event(srlm_pkg::KIND_SCLK_RISE, val[7 - (i % 8)]));
  endtask

  task automatic send_random_bits(input int n);
    int i;
    for (i = 0; i < n; i++)
      push_event(rand_event(srlm_pkg::KIND_SCLK_RISE, 1'($urandom_range(0, 1))));
  endtask

  task automatic send_release();
    push_event(rand_event(srlm_pkg::KIND_CS_RELEASE, 1'($urandom_range(0, 1))));
  endtask

  task automatic send_ticks(input int n);
    link_event_t ev;
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) mot_up = ~mot_up;
      ev = rand_event(srlm_pkg::KIND_TICK, 1'($urandom_range(0, 1)));
      ev.mot = mot_up;
      push_event(ev);
    end
  endtask

  task automatic send_read(input logic [7:0] cmd);
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8 * 34) : $urandom_range(0, 8 * 15);
    send_bits(cmd, 8);
    send_random_bits(n);
    send_release();
  endtask

  task automatic random_traffic(input int unsigned budget);
    int unsigned stop, sel, longest;
    logic [7:0] cmd;
    int i, n;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
        // full transmit / reply / read-back exchange
        if ($urandom_range(0, 4) != 0) send_ticks(1);
        case ($urandom_range(0, 5))
          0: send_bits(srlm_pkg::CMD_TX_START, 4);
          1: send_bits(srlm_pkg::CMD_WAIT_RESET, 8);
          default: send_bits(srlm_pkg::CMD_TX_START, 8);
        endcase
        if ($urandom_range(0, 2) == 0) send_random_bits($urandom_range(0, 23));
        send_release();
        longest = (cfg_tx_delay > cfg_reply_delay) ? cfg_tx_delay : cfg_reply_delay;
        send_ticks($urandom_range(1, longest + 3));
        send_read(srlm_pkg::CMD_LATCH_RX);
      end else if (sel < 50) begin
        cmd = ($urandom_range(0, 1) == 0) ? srlm_pkg::CMD_LATCH_RX
                                          : (CMD_READ_BASE | 8'($urandom_range(0, 63)));
        send_read(cmd);
      end else if (sel < 65) begin
        cmd = ($urandom_range(0, 3) == 0) ? CMD_DATA_DROP : 8'($urandom_range(0, 255));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 8;
        send_bits(cmd, n);
        if (n == 8) send_random_bits($urandom_range(0, 27));
        send_release();
      end else if (sel < 75) begin
        send_bits(srlm_pkg::CMD_WAIT_RESET, ($urandom_range(0, 2) == 0) ? 2 : 8);
        send_release();
        send_ticks($urandom_range(1, 12));
      end else if (sel < 88) begin
        send_ticks(($urandom_range(0, 7) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40));
      end else begin
        // noise, ignored kind included
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++)
          push_event(rand_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
      end
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_config(input logic [7:0] tx, input logic [7:0] reply,
                             input logic [15:0] step, input logic [15:0] limit);
    logic [31:0] vals [4];
    int r;
    vals[srlm_pkg::REG_TX_DONE_DELAY] = {24'b0, tx};
    vals[srlm_pkg::REG_REPLY_DELAY] = {24'b0, reply};
    vals[srlm_pkg::REG_ACCEL_STEP] = {16'b0, step};
    vals[srlm_pkg::REG_ACCEL_LIMIT] = {16'b0, limit};
    for (r = 0; r < 4; r++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r[1:0], 2'b00};
      pwdata <= vals[r];
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_tx_delay = tx;
    cfg_reply_delay = reply;
    cfg_step = step;
    cfg_limit = limit;
  endtask

  // kind, dbit, mot, buttons, typed, drive_valid, drive_bit, status, irqs
  script_row_t script [26] = '{
    '{KIND_UNUSED,               1'b1, 1'b1, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0},
    // partial 0xd0 ahead of any tick: timer stays unarmed
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b1, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b1, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0},
    '{srlm_pkg::KIND_CS_RELEASE, 1'b0, 1'b0, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0},
    '{srlm_pkg::KIND_TICK,       1'b0, 1'b1, 16'hffff, 1'b1, 1'b0, 1'b0, 1'b1, 2'd0},
    // partial 0xc0 arms the wait, then tx done after five ticks
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b1, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_CS_RELEASE, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_TICK,       1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_TICK,       1'b0, 1'b1, 16'ha5a5, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_TICK,       1'b1, 1'b0, 16'h5a5a, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_TICK,       1'b0, 1'b1, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_TICK,       1'b1, 1'b0, 16'h0001, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    // 0x45 with no packet yet, then reads of the empty buffer
    '{srlm_pkg::KIND_SCLK_RISE,  1'b0, 1'b0, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b0, 1'b0, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b0, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b0, 1'b0, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b0, 1'b0, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b0, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_SCLK_RISE,  1'b1, 1'b1, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0},
    '{srlm_pkg::KIND_CS_RELEASE, 1'b0, 1'b1, 16'hffff, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0}
  };

  initial begin
    link_event_t ev;
    link_result_t want;
    int i;
    link_reset();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 26; i++) begin
      ev = '{script[i].kind, script[i].dbit, script[i].mot, script[i].buttons};
      want = '{script[i].drv_valid, script[i].drv_bit, script[i].status, script[i].irqs};
      push_event(ev, script[i].typed, want);
    end
    // each traffic call runs past its budget by part of an exchange
    random_traffic(80);
    drain();

    load_config(8'd1, 8'd1, 16'd0, 16'd0);
    random_traffic(70);
    drain();
    load_config(8'd255, 8'd255, 16'hffff, 16'hffff);
    random_traffic(90);
    drain();
    load_config(8'd2, 8'd9, 16'd20000, 16'hffff);
    random_traffic(70);
    drain();
    repeat (3) begin
      load_config(8'($urandom_range(1, 12)), 8'($urandom_range(1, 40)),
                  16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      random_traffic(65);
      drain();
    end

    if (errors == 0) begin
      $display("** serial_radio_link_model_core: PASSED **");
    end else begin
      $display("** serial_radio_link_model_core: FAILED **");
    end
    $finish;
  end

endmodule
